FILE: rtl/quad_encoder_decoder_skip_recover_defines.svh
// ---------------------------------------------------------------------------
// Quadrature decoder assertion macros
// Concurrent check wrappers; empty bodies when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef QUAD_ENCODER_DECODER_SKIP_RECOVER_DEFINES_SVH
`define QUAD_ENCODER_DECODER_SKIP_RECOVER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define QEDSR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qedsr assertion failed");

// next-cycle implication
`define QEDSR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qedsr assertion failed");

`else

`define QEDSR_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define QEDSR_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/qedsr_pkg.sv
// ---------------------------------------------------------------------------
// qedsr_pkg
// Shared constants, types and the phase mapping for the quadrature decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package qedsr_pkg;

   localparam int LANE_COUNT  = 4;
   localparam int COUNT_WIDTH = 32;
   localparam int POS_WIDTH   = 32;
   localparam int SKIP_STEP   = 2;

   localparam int IN_FIELD_BITS  = 2 * LANE_COUNT;
   localparam int IN_WIDTH       = ((IN_FIELD_BITS + 7) / 8) * 8;
   localparam int OUT_FIELD_BITS = LANE_COUNT * (POS_WIDTH + 1);
   localparam int OUT_WIDTH      = ((OUT_FIELD_BITS + 7) / 8) * 8;

   localparam logic [COUNT_WIDTH-1:0] COUNT_ONE  = COUNT_WIDTH'(1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_SKIP = COUNT_WIDTH'(SKIP_STEP);

   // phase difference codes
   localparam logic [1:0] STEP_NONE = 2'd0;
   localparam logic [1:0] STEP_FWD  = 2'd1;
   localparam logic [1:0] STEP_SKIP = 2'd2;
   localparam logic [1:0] STEP_BACK = 2'd3;

   typedef struct packed {
      logic [POS_WIDTH-1:0] position;
      logic                 backward;
   } lane_result_type;

   // 00 -> 0, 01 -> 1, 11 -> 2, 10 -> 3 (Gray to binary)
   function automatic logic [1:0] phase_of(input logic [1:0] pattern);
      return {pattern[1], pattern[1] ^ pattern[0]};
   endfunction

   // low bits of the count, zero extended when the count is narrower
   function automatic logic [POS_WIDTH-1:0] to_position(input logic [COUNT_WIDTH-1:0] count);
      return POS_WIDTH'(count);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/quad_encoder_decoder_skip_recover.sv
// ---------------------------------------------------------------------------
// quad_encoder_decoder_skip_recover
// Four quadrature decoders (telescope alt/azm, motor alt/azm) with recovery
// of skipped steps; one pin sample in, one set of positions out.
// ---------------------------------------------------------------------------
//
//  channel | dir | handshake                | payload
//  --------+-----+--------------------------+-----------------------------------
//  req     | in  | req_tvalid / req_tready  | 8 pin levels, A/B per lane
//  rsp     | out | rsp_tvalid / rsp_tready  | 4 x 32-bit position, 4 direction
//
//  One item per clock, sustained while the consumer keeps up: each lane is a 2-bit
//  phase subtract and one count add/subtract, computed combinationally on acceptance.
//  Lane state updates on acceptance; results sit in an output register with a
//  one-item skid stage, so req_tready only drops after two stalled results.
//  Reset (synchronous) clears all patterns to 00, directions to forward and
//  counts to zero; the first sample is compared against 00.
//
`default_nettype none

module quad_encoder_decoder_skip_recover (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [0] tube_alt_a [1] tube_alt_b [2] tube_azm_a [3] tube_azm_b
   // [4] motor_alt_a [5] motor_alt_b [6] motor_azm_a [7] motor_azm_b
   input  wire logic [qedsr_pkg::IN_WIDTH-1:0]    req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [31:0] tube_alt_position [63:32] tube_azm_position
   // [95:64] motor_alt_position [127:96] motor_azm_position
   // [128] tube_alt_backward [129] tube_azm_backward
   // [130] motor_alt_backward [131] motor_azm_backward, rest zero
   output logic [qedsr_pkg::OUT_WIDTH-1:0]        rsp_tdata
);

   logic                                                        accept;
   qedsr_pkg::lane_result_type [qedsr_pkg::LANE_COUNT-1:0]      lane_res;

   assign accept = req_tvalid & req_tready;

   // one decoder per A/B pair; A at the even bit, B at the odd bit
   for (genvar g = 0; g < qedsr_pkg::LANE_COUNT; g++) begin : g_lane
      qedsr_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .accept (accept),
         .pin_a  (req_tdata[2*g]),
         .pin_b  (req_tdata[2*g+1]),
         .result (lane_res[g])
      );
   end

   // gather lane results into one item and hold it for the consumer
   qedsr_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .lane_res  (lane_res),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule

`default_nettype wire

FILE: rtl/qedsr_lane.sv
// ---------------------------------------------------------------------------
// qedsr_lane
// One quadrature decoder: pattern, direction and count, with skip recovery.
// ---------------------------------------------------------------------------
`default_nettype none

`include "quad_encoder_decoder_skip_recover_defines.svh"

module qedsr_lane (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       accept,
   input  wire logic                       pin_a,
   input  wire logic                       pin_b,
   output qedsr_pkg::lane_result_type      result
);

   logic [1:0]                        pattern_ff;
   logic [1:0]                        pattern_in;
   logic                              backward_ff;
   logic                              backward_in;
   logic [qedsr_pkg::COUNT_WIDTH-1:0] count_ff;
   logic [qedsr_pkg::COUNT_WIDTH-1:0] count_in;
   logic [1:0]                        step;

   assign pattern_in = {pin_a, pin_b};
   assign step = qedsr_pkg::phase_of(pattern_in) - qedsr_pkg::phase_of(pattern_ff);

   always_comb begin
      count_in    = count_ff;
      backward_in = backward_ff;
      case (step)
         qedsr_pkg::STEP_FWD: begin
            count_in    = count_ff + qedsr_pkg::COUNT_ONE;
            backward_in = 1'b0;
         end
         qedsr_pkg::STEP_BACK: begin
            count_in    = count_ff - qedsr_pkg::COUNT_ONE;
            backward_in = 1'b1;
         end
         qedsr_pkg::STEP_SKIP: begin
            // both pins moved: trust the remembered direction
            count_in = backward_ff ? count_ff - qedsr_pkg::COUNT_SKIP
                                   : count_ff + qedsr_pkg::COUNT_SKIP;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff  <= 2'b00;
         backward_ff <= 1'b0;
         count_ff    <= '0;
      end else if (accept) begin
         pattern_ff  <= pattern_in;
         backward_ff <= backward_in;
         count_ff    <= count_in;
      end
   end

   assign result.position = qedsr_pkg::to_position(count_in);
   assign result.backward = backward_in;

   // unchanged pins leave the lane alone
   `QEDSR_ASSERT_NXT(a_idle_holds, clock, reset,
      accept && pattern_in == pattern_ff, $stable(count_ff) && $stable(backward_ff))

endmodule

`default_nettype wire

FILE: rtl/qedsr_merge.sv
// ---------------------------------------------------------------------------
// qedsr_merge
// Packs the lane results into one item and buffers it (output + skid stage).
// ---------------------------------------------------------------------------
`default_nettype none

`include "quad_encoder_decoder_skip_recover_defines.svh"

module qedsr_merge (
   input  wire logic                                                   clock,
   input  wire logic                                                   reset,
   input  wire logic                                                   push,
   input  wire qedsr_pkg::lane_result_type [qedsr_pkg::LANE_COUNT-1:0] lane_res,
   output logic                                                        in_ready,
   output logic                                                        out_valid,
   input  wire logic                                                   out_ready,
   output logic [qedsr_pkg::OUT_WIDTH-1:0]                             out_data
);

   logic [qedsr_pkg::OUT_WIDTH-1:0] packed_in;
   logic [qedsr_pkg::OUT_WIDTH-1:0] out_data_ff;
   logic [qedsr_pkg::OUT_WIDTH-1:0] skid_data_ff;
   logic                            out_valid_ff;
   logic                            skid_valid_ff;
   logic                            pop;

   // positions in lane order from bit 0, then one direction bit per lane
   always_comb begin
      packed_in = '0;
      for (int i = 0; i < qedsr_pkg::LANE_COUNT; i++) begin
         packed_in[i*qedsr_pkg::POS_WIDTH +: qedsr_pkg::POS_WIDTH] = lane_res[i].position;
         packed_in[qedsr_pkg::LANE_COUNT*qedsr_pkg::POS_WIDTH + i] = lane_res[i].backward;
      end
   end

   assign pop      = out_valid_ff & out_ready;
   assign in_ready = ~skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff  <= skid_valid_ff;
         skid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_ff <= packed_in;
         end else begin
            skid_data_ff <= packed_in;
         end
      end else if (pop) begin
         out_data_ff <= skid_data_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   `QEDSR_ASSERT_IMP(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `QEDSR_ASSERT_NXT(a_stall_fills_skid, clock, reset,
      push && out_valid_ff && !pop, skid_valid_ff)
   `QEDSR_ASSERT_NXT(a_skid_moves_up, clock, reset,
      pop && skid_valid_ff && !push, out_valid_ff && !skid_valid_ff)

endmodule

`default_nettype wire
